@@ src/fcc_pkg.sv @@
package fcc_pkg;

  // field widths of the request and result
  localparam int OP_W    = 2;
  localparam int INDEX_W = 14;
  localparam int VALUE_W = 15;
  localparam int NC_W    = 11;
  localparam int TOTAL_W = 36;

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_OFFSET   = 2'd0,
    OP_NEIGHBOR = 2'd1,
    OP_START    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_OFF_LO,
    CMD_OFF_HI,
    CMD_OFF_END,
    CMD_SPAN_EMPTY,
    CMD_ADJ_RD,
    CMD_ADJ_TAKE,
    CMD_V1_INC,
    CMD_SETUP,
    CMD_SRCH_RD,
    CMD_SRCH_CMP,
    CMD_COUNT,
    CMD_PUBLISH
  } cmd_op_t;

  // path node select
  typedef enum logic [1:0] {
    SEL_V1 = 2'd0,
    SEL_V2 = 2'd1,
    SEL_V3 = 2'd2,
    SEL_V4 = 2'd3
  } sel_t;

  // span destination: walk levels or the two search endpoints
  typedef enum logic [2:0] {
    DST_L1 = 3'd0,
    DST_L2 = 3'd1,
    DST_L3 = 3'd2,
    DST_U  = 3'd3,
    DST_V  = 3'd4
  } dst_t;

  typedef struct packed {
    cmd_op_t op;
    sel_t    sel;
    sel_t    sel2;
    dst_t    dst;
  } cmd_t;

  typedef struct packed {
    logic node_ok;
    logic v1_end;
    logic lvl_end;
    logic adj_gt;
    logic search_end;
    logic hit;
  } status_t;

endpackage

@@ src/fcc_ram.sv @@
module fcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fcc_datapath.sv @@
module fcc_datapath #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 16384
) (
  input  logic                          clk,
  input  fcc_pkg::cmd_t                 cmd,
  input  fcc_pkg::op_t                  op,
  input  logic [fcc_pkg::INDEX_W-1:0]   index,
  input  logic [fcc_pkg::VALUE_W-1:0]   value,
  input  logic [fcc_pkg::NC_W-1:0]      node_count,
  output fcc_pkg::status_t              status,
  output logic [fcc_pkg::TOTAL_W-1:0]   clique_count
);

  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int AAW = $clog2(MAX_EDGES);
  localparam int OAW = $clog2(MAX_NODES + 1);
  localparam int VW  = fcc_pkg::VALUE_W;
  localparam logic [EW-1:0] EDGE_LIMIT = EW'(MAX_EDGES);

  logic [fcc_pkg::NC_W-1:0]    n;
  logic [VW-1:0]               v1, v2, v3, v4, key;
  logic [EW-1:0]               i1, e1, i2, e2, i3, e3;
  logic [EW-1:0]               ub, ue, vb, ve, sb, b, e, m;
  logic [fcc_pkg::TOTAL_W-1:0] total;

  logic           off_we, adj_we;
  logic [OAW-1:0] off_raddr;
  logic [AAW-1:0] adj_raddr;
  logic [VW-1:0]  off_rdata, adj_rdata;
  logic [VW-1:0]  node_a, node_b, lvl_node;
  logic [EW-1:0]  lvl_pos, lvl_end_pos, hi, m_calc;

  function automatic logic [EW-1:0] clamp_off(input logic [VW-1:0] off);
    if (32'(off) > MAX_EDGES) return EDGE_LIMIT;
    return EW'(off);
  endfunction

  function automatic logic [VW-1:0] pick_node(input fcc_pkg::sel_t s,
      input logic [VW-1:0] a, input logic [VW-1:0] bb,
      input logic [VW-1:0] c, input logic [VW-1:0] d);
    logic [VW-1:0] r;
    unique case (s)
      fcc_pkg::SEL_V1: r = a;
      fcc_pkg::SEL_V2: r = bb;
      fcc_pkg::SEL_V3: r = c;
      default:         r = d;
    endcase
    return r;
  endfunction

  // graph stores
  fcc_ram #(.WIDTH(VW), .DEPTH(MAX_NODES + 1)) u_offsets (
    .clk(clk), .we(off_we), .waddr(OAW'(index)), .wdata(value),
    .raddr(off_raddr), .rdata(off_rdata)
  );

  fcc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_adjacency (
    .clk(clk), .we(adj_we), .waddr(AAW'(index)), .wdata(value),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  // load writes, dropped when the slot is out of range
  assign off_we = (cmd.op == fcc_pkg::CMD_LOAD) && (op == fcc_pkg::OP_OFFSET)
                  && (32'(index) <= MAX_NODES);
  assign adj_we = (cmd.op == fcc_pkg::CMD_LOAD) && (op == fcc_pkg::OP_NEIGHBOR)
                  && (32'(index) < MAX_EDGES);

  // node and level selection
  always_comb begin
    node_a = pick_node(cmd.sel, v1, v2, v3, v4);
    node_b = pick_node(cmd.sel2, v1, v2, v3, v4);
    unique case (cmd.dst)
      fcc_pkg::DST_L1: begin
        lvl_pos = i1; lvl_end_pos = e1; lvl_node = v1;
      end
      fcc_pkg::DST_L2: begin
        lvl_pos = i2; lvl_end_pos = e2; lvl_node = v2;
      end
      default: begin
        lvl_pos = i3; lvl_end_pos = e3; lvl_node = v3;
      end
    endcase
  end

  // memory read addresses and span upper bound
  always_comb begin
    m_calc    = b + ((e - b) >> 1);
    off_raddr = (cmd.op == fcc_pkg::CMD_OFF_HI) ? OAW'({1'b0, node_a} + 16'd1)
                                                : OAW'(node_a);
    adj_raddr = (cmd.op == fcc_pkg::CMD_SRCH_RD) ? AAW'(m_calc) : AAW'(lvl_pos);
    hi        = clamp_off(off_rdata);
    if (hi < sb) hi = sb;
  end

  // status back to the controller
  always_comb begin
    status.node_ok    = node_a < VW'(n);
    status.v1_end     = v1 >= VW'(n);
    status.lvl_end    = lvl_pos >= lvl_end_pos;
    status.adj_gt     = adj_rdata > lvl_node;
    status.search_end = b >= e;
    status.hit        = adj_rdata == key;
  end

  // command execution
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      fcc_pkg::CMD_START: begin
        total <= '0;
        v1    <= '0;
        if (32'(node_count) > MAX_NODES) n <= fcc_pkg::NC_W'(MAX_NODES);
        else n <= node_count;
      end
      fcc_pkg::CMD_OFF_HI: sb <= clamp_off(off_rdata);
      fcc_pkg::CMD_OFF_END, fcc_pkg::CMD_SPAN_EMPTY: begin
        logic [EW-1:0] lo_w, hi_w;
        lo_w = (cmd.op == fcc_pkg::CMD_OFF_END) ? sb : '0;
        hi_w = (cmd.op == fcc_pkg::CMD_OFF_END) ? hi : '0;
        unique case (cmd.dst)
          fcc_pkg::DST_L1: begin i1 <= lo_w; e1 <= hi_w; end
          fcc_pkg::DST_L2: begin i2 <= lo_w; e2 <= hi_w; end
          fcc_pkg::DST_L3: begin i3 <= lo_w; e3 <= hi_w; end
          fcc_pkg::DST_U:  begin ub <= lo_w; ue <= hi_w; end
          default:         begin vb <= lo_w; ve <= hi_w; end
        endcase
      end
      fcc_pkg::CMD_ADJ_RD: begin
        unique case (cmd.dst)
          fcc_pkg::DST_L1: i1 <= i1 + 1'b1;
          fcc_pkg::DST_L2: i2 <= i2 + 1'b1;
          default:         i3 <= i3 + 1'b1;
        endcase
      end
      fcc_pkg::CMD_ADJ_TAKE: begin
        unique case (cmd.dst)
          fcc_pkg::DST_L1: v2 <= adj_rdata;
          fcc_pkg::DST_L2: v3 <= adj_rdata;
          default:         v4 <= adj_rdata;
        endcase
      end
      fcc_pkg::CMD_V1_INC: v1 <= v1 + 1'b1;
      fcc_pkg::CMD_SETUP: begin
        if ((ue - ub) > (ve - vb)) begin
          b <= vb; e <= ve; key <= node_a;
        end else begin
          b <= ub; e <= ue; key <= node_b;
        end
      end
      fcc_pkg::CMD_SRCH_RD: m <= m_calc;
      fcc_pkg::CMD_SRCH_CMP: begin
        if (adj_rdata > key) e <= m;
        else b <= m + 1'b1;
      end
      fcc_pkg::CMD_COUNT:   total <= total + 1'b1;
      fcc_pkg::CMD_PUBLISH: clique_count <= total;
      default: ;
    endcase
  end

endmodule

@@ src/fcc_controller.sv @@
module fcc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fcc_pkg::op_t     op,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  fcc_pkg::status_t status,
  output fcc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_L1_TOP, ST_ITER, ST_TAKE, ST_SPAN_LO, ST_SPAN_HI, ST_SPAN_END,
    ST_CHK_U, ST_CHK_V, ST_SETUP, ST_SRCH_TEST, ST_SRCH_RD, ST_SRCH_CMP,
    ST_COUNT, ST_DONE
  } state_t;

  state_t          state, ret;
  fcc_pkg::sel_t   span_sel;
  fcc_pkg::dst_t   span_dst, lvl;
  logic [1:0]      chk;
  logic            can_publish;
  fcc_pkg::sel_t   chk_u, chk_v;

  assign s_tready    = (state == ST_IDLE);
  assign can_publish = !m_tvalid || m_tready;

  // edge checks: v1-v3, v1-v4, v2-v4
  always_comb begin
    chk_u = (chk == 2'd2) ? fcc_pkg::SEL_V2 : fcc_pkg::SEL_V1;
    chk_v = (chk == 2'd0) ? fcc_pkg::SEL_V3 : fcc_pkg::SEL_V4;
  end

  // command decode
  always_comb begin
    cmd = '{op: fcc_pkg::CMD_NONE, sel: span_sel, sel2: chk_v, dst: lvl};
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (op == fcc_pkg::OP_OFFSET || op == fcc_pkg::OP_NEIGHBOR)
            cmd.op = fcc_pkg::CMD_LOAD;
          else if (op == fcc_pkg::OP_START)
            cmd.op = fcc_pkg::CMD_START;
        end
      end
      ST_L1_TOP: cmd.sel = fcc_pkg::SEL_V1;
      ST_ITER: begin
        if (!status.lvl_end) cmd.op = fcc_pkg::CMD_ADJ_RD;
        else if (lvl == fcc_pkg::DST_L1) cmd.op = fcc_pkg::CMD_V1_INC;
      end
      ST_TAKE: cmd.op = fcc_pkg::CMD_ADJ_TAKE;
      ST_SPAN_LO: begin
        cmd.dst = span_dst;
        cmd.op  = status.node_ok ? fcc_pkg::CMD_OFF_LO : fcc_pkg::CMD_SPAN_EMPTY;
      end
      ST_SPAN_HI: cmd.op = fcc_pkg::CMD_OFF_HI;
      ST_SPAN_END: begin
        cmd.dst = span_dst;
        cmd.op  = fcc_pkg::CMD_OFF_END;
      end
      ST_SETUP: begin
        cmd.op  = fcc_pkg::CMD_SETUP;
        cmd.sel = chk_u;
      end
      ST_SRCH_RD:  cmd.op = fcc_pkg::CMD_SRCH_RD;
      ST_SRCH_CMP: cmd.op = fcc_pkg::CMD_SRCH_CMP;
      ST_COUNT:    cmd.op = fcc_pkg::CMD_COUNT;
      ST_DONE:     if (can_publish) cmd.op = fcc_pkg::CMD_PUBLISH;
      default: ;
    endcase
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      span_sel <= fcc_pkg::SEL_V1;
      span_dst <= fcc_pkg::DST_L1;
      lvl      <= fcc_pkg::DST_L1;
      chk      <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !(state == ST_DONE && can_publish)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && op == fcc_pkg::OP_START) state <= ST_L1_TOP;
        end
        ST_L1_TOP: begin
          if (status.v1_end) begin
            state <= ST_DONE;
          end else begin
            span_sel <= fcc_pkg::SEL_V1;
            span_dst <= fcc_pkg::DST_L1;
            lvl      <= fcc_pkg::DST_L1;
            ret      <= ST_ITER;
            state    <= ST_SPAN_LO;
          end
        end
        ST_ITER: begin
          if (!status.lvl_end) state <= ST_TAKE;
          else if (lvl == fcc_pkg::DST_L1) state <= ST_L1_TOP;
          else if (lvl == fcc_pkg::DST_L2) lvl <= fcc_pkg::DST_L1;
          else lvl <= fcc_pkg::DST_L2;
        end
        ST_TAKE: begin
          if (!status.adj_gt) begin
            state <= ST_ITER;
          end else if (lvl == fcc_pkg::DST_L3) begin
            chk   <= 2'd0;
            state <= ST_CHK_U;
          end else begin
            ret   <= ST_ITER;
            state <= ST_SPAN_LO;
            if (lvl == fcc_pkg::DST_L1) begin
              span_sel <= fcc_pkg::SEL_V2;
              span_dst <= fcc_pkg::DST_L2;
              lvl      <= fcc_pkg::DST_L2;
            end else begin
              span_sel <= fcc_pkg::SEL_V3;
              span_dst <= fcc_pkg::DST_L3;
              lvl      <= fcc_pkg::DST_L3;
            end
          end
        end
        ST_SPAN_LO:  state <= status.node_ok ? ST_SPAN_HI : ret;
        ST_SPAN_HI:  state <= ST_SPAN_END;
        ST_SPAN_END: state <= ret;
        ST_CHK_U: begin
          span_sel <= chk_u;
          span_dst <= fcc_pkg::DST_U;
          ret      <= ST_CHK_V;
          state    <= ST_SPAN_LO;
        end
        ST_CHK_V: begin
          span_sel <= chk_v;
          span_dst <= fcc_pkg::DST_V;
          ret      <= ST_SETUP;
          state    <= ST_SPAN_LO;
        end
        ST_SETUP:     state <= ST_SRCH_TEST;
        ST_SRCH_TEST: state <= status.search_end ? ST_ITER : ST_SRCH_RD;
        ST_SRCH_RD:   state <= ST_SRCH_CMP;
        ST_SRCH_CMP: begin
          if (!status.hit) begin
            state <= ST_SRCH_TEST;
          end else if (chk == 2'd2) begin
            state <= ST_COUNT;
          end else begin
            chk   <= chk + 2'd1;
            state <= ST_CHK_U;
          end
        end
        ST_COUNT: state <= ST_ITER;
        ST_DONE: begin
          if (can_publish) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a start request begins the walk at the first node
  a_start_walks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && op == fcc_pkg::OP_START) |=> state == ST_L1_TOP)
    else $error("start request did not begin the walk");

  // the result is raised when the count finishes and the output is free
  a_publish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && can_publish) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished count not published");

  // a search compare always follows its read
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_SRCH_CMP |-> $past(state) == ST_SRCH_RD)
    else $error("search compare without read");

  // the check counter never passes the last edge check
  a_chk_range: assert property (@(posedge clk) disable iff (rst)
    chk != 2'd3)
    else $error("edge check index out of range");

endmodule

@@ src/four_clique_counter_unit.sv @@
// four-clique counter
// input stream: load requests write one row offset (op 0) or one neighbor
// entry (op 1), one per cycle while idle; a start request (op 2) carries the node count
// and counts the 4-cliques of the loaded graph in compressed sparse row form.
// each neighbor list should be sorted ascending.
// output stream: one result per start, the 36-bit clique total.
// a start walks every increasing path v1<v2<v3<v4: it looks up the list
// spans of v1, v2 and v3, reads each list entry, and for each edge check it
// looks up two list spans, sets up and runs a binary search over the shorter.
// all of it goes through the single read port of the neighbor memory and
// the offset memory, one access a cycle.
// s_tready is low while counting; load requests wait until the result has
// been moved to the output register.
// a result that the receiver stalls stays in the output register; the block
// takes new loads meanwhile, and a following count waits at its end until
// the output register is free.
// reset returns the controller to idle and drops m_tvalid; the graph memories
// are not cleared and must be written before use.
module four_clique_counter_unit #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // op[1:0], index[15:2], value[30:16], node_count[41:31]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // clique_count[35:0]
);

  fcc_pkg::cmd_t                 cmd;
  fcc_pkg::status_t              status;
  fcc_pkg::op_t                  op;
  logic [fcc_pkg::TOTAL_W-1:0]   clique_count;

  // request unpacking
  assign op = fcc_pkg::op_t'(s_tdata[1:0]);

  fcc_controller u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .op(op),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .status(status), .cmd(cmd)
  );

  fcc_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .cmd(cmd), .op(op), .index(s_tdata[15:2]),
    .value(s_tdata[30:16]), .node_count(s_tdata[41:31]),
    .status(status), .clique_count(clique_count)
  );

  // result packing
  assign m_tdata = {4'd0, clique_count};

endmodule
